>>> rtl/core/mmc_spi_host_sequencer_unit_defines.svh
// assertion macros shared by the mmc spi host sequencer rtl
`ifndef MMC_SPI_HOST_SEQUENCER_UNIT_DEFINES_SVH
`define MMC_SPI_HOST_SEQUENCER_UNIT_DEFINES_SVH

// checked on every rising edge once reset is released
`define MMC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked on every rising edge, reset included
`define MMC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/core/mmc_pkg.sv
// types and constants of the mmc spi host sequencer
`timescale 1ns / 1ps
package mmc_pkg;

	localparam int CMD_IDX_W = 6;
	localparam int COUNT_W   = 10;
	localparam int FRAME_W   = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [1:0] CMD_INIT = 2'd0;
	localparam logic [1:0] CMD_READ = 2'd1;
	localparam logic [1:0] CMD_BYTE = 2'd2;

	localparam logic [1:0] ST_BUSY   = 2'd0;
	localparam logic [1:0] ST_DONE   = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_IDLE_CMD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OPMODE_CMD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_READ_CMD   = 2'd2;

	localparam logic [CMD_IDX_W-1:0] IDLE_CMD_RST   = 6'd0;
	localparam logic [CMD_IDX_W-1:0] OPMODE_CMD_RST = 6'd1;
	localparam logic [CMD_IDX_W-1:0] READ_CMD_RST   = 6'd17;

	localparam logic [7:0] CMD_MARK   = 8'h40;
	localparam logic [7:0] IDLE_CRC   = 8'h95;
	localparam logic [7:0] FILL_BYTE  = 8'hFF;
	localparam logic [7:0] DATA_TOKEN = 8'hFE;
	localparam logic [7:0] RESP_IDLE  = 8'h01;
	localparam logic [7:0] RESP_READY = 8'h00;

	localparam logic [FRAME_W-1:0] FRAME_LAST = 4'd8;

	localparam logic OP_INIT = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_WAKE     = 4'd1,
		PH_CMD_IDLE = 4'd2,
		PH_CMD_OP   = 4'd3,
		PH_CMD_READ = 4'd4,
		PH_TOKEN    = 4'd5,
		PH_DATA     = 4'd6,
		PH_CRC      = 4'd7
	} phase_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [31:0] sector_address;
		logic [7:0]  rx_byte;
	} in_item_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       card_select;
		logic       data_valid;
		logic [7:0] data_byte;
		logic       data_last;
		logic [1:0] status;
	} out_item_t;

	typedef struct packed {
		logic [CMD_IDX_W-1:0] idle_cmd_index;
		logic [CMD_IDX_W-1:0] opmode_cmd_index;
		logic [CMD_IDX_W-1:0] read_cmd_index;
	} cfg_t;

	typedef struct packed {
		phase_t               phase;
		logic                 operation;
		logic [FRAME_W-1:0]   frame_index;
		logic [COUNT_W-1:0]   byte_count;
		logic [31:0]          address_latch;
		logic [CMD_IDX_W-1:0] command_index;
	} seq_state_t;

endpackage

>>> rtl/core/mmc_cfg_regs.sv
// command index registers written through the configuration port
`timescale 1ns / 1ps
module mmc_cfg_regs
	import mmc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CMD_IDX_W-1:0] cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_cmd_index   <= IDLE_CMD_RST;
			cfg_q.opmode_cmd_index <= OPMODE_CMD_RST;
			cfg_q.read_cmd_index   <= READ_CMD_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_IDLE_CMD:   cfg_q.idle_cmd_index   <= cfg_data;
				REG_OPMODE_CMD: cfg_q.opmode_cmd_index <= cfg_data;
				REG_READ_CMD:   cfg_q.read_cmd_index   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/mmc_step.sv
// per transaction next state and result logic of the sequencer
`timescale 1ns / 1ps
module mmc_step
	import mmc_pkg::*;
#(
	parameter int SECTOR_BYTES = 512,
	parameter int WAKE_BYTES   = 10
) (
	input  seq_state_t cur,
	input  in_item_t   item,
	input  cfg_t       cfg,
	output seq_state_t nxt,
	output out_item_t  res
);

	logic [COUNT_W-1:0] cnt_inc;
	logic [COUNT_W:0]   cnt_inc_wide;
	logic [7:0]         frame_byte;
	logic               data_valid_c;
	logic [7:0]         data_byte_c;
	logic               data_last_c;
	logic [1:0]         status_c;

	assign cnt_inc      = cur.byte_count + 1'b1;
	assign cnt_inc_wide = {1'b0, cur.byte_count} + 1'b1;

	always_comb begin
		nxt          = cur;
		data_valid_c = 1'b0;
		data_byte_c  = 8'h00;
		data_last_c  = 1'b0;
		status_c     = ST_BUSY;
		unique case (item.command)
			CMD_INIT: begin
				nxt.operation   = OP_INIT;
				nxt.phase       = PH_WAKE;
				nxt.byte_count  = '0;
				nxt.frame_index = '0;
			end
			CMD_READ: begin
				nxt.operation     = OP_READ;
				nxt.byte_count    = '0;
				nxt.phase         = PH_CMD_READ;
				nxt.frame_index   = '0;
				nxt.command_index = cfg.read_cmd_index;
				nxt.address_latch = item.sector_address;
			end
			CMD_BYTE: begin
				unique case (cur.phase)
					PH_WAKE: begin
						nxt.byte_count = cnt_inc;
						if (cnt_inc >= COUNT_W'(WAKE_BYTES)) begin
							nxt.phase         = PH_CMD_IDLE;
							nxt.frame_index   = '0;
							nxt.command_index = cfg.idle_cmd_index;
							nxt.address_latch = '0;
						end
					end
					PH_CMD_IDLE, PH_CMD_OP, PH_CMD_READ: begin
						if (cur.frame_index < FRAME_LAST) begin
							nxt.frame_index = cur.frame_index + 1'b1;
						end else if (cur.phase == PH_CMD_IDLE) begin
							if (item.rx_byte == RESP_IDLE) begin
								nxt.phase         = PH_CMD_OP;
								nxt.frame_index   = '0;
								nxt.command_index = cfg.opmode_cmd_index;
								nxt.address_latch = '0;
							end else begin
								nxt.phase = PH_IDLE;
								status_c  = ST_REJECT;
							end
						end else if (cur.phase == PH_CMD_OP) begin
							if (item.rx_byte == RESP_READY) begin
								nxt.phase = PH_IDLE;
								status_c  = ST_DONE;
							end else begin
								nxt.frame_index = '0;
							end
						end else begin
							nxt.phase = PH_TOKEN;
						end
					end
					PH_TOKEN: begin
						if (item.rx_byte == DATA_TOKEN) begin
							nxt.phase      = PH_DATA;
							nxt.byte_count = '0;
						end
					end
					PH_DATA: begin
						data_valid_c = 1'b1;
						data_byte_c  = item.rx_byte;
						if (cnt_inc_wide >= (COUNT_W+1)'(SECTOR_BYTES)) begin
							data_last_c    = 1'b1;
							nxt.phase      = PH_CRC;
							nxt.byte_count = '0;
						end else begin
							nxt.byte_count = cnt_inc;
						end
					end
					PH_CRC: begin
						nxt.byte_count = cnt_inc;
						if (cnt_inc >= COUNT_W'(2)) begin
							nxt.phase      = PH_IDLE;
							nxt.byte_count = '0;
							status_c       = ST_DONE;
						end
					end
					default: nxt.phase = PH_IDLE;
				endcase
			end
			default: ;
		endcase
	end

	// byte of the command frame for the pending exchange
	always_comb begin
		unique case (nxt.frame_index)
			4'd1:    frame_byte = CMD_MARK | {2'b00, nxt.command_index};
			4'd2:    frame_byte = nxt.address_latch[31:24];
			4'd3:    frame_byte = nxt.address_latch[23:16];
			4'd4:    frame_byte = nxt.address_latch[15:8];
			4'd5:    frame_byte = nxt.address_latch[7:0];
			4'd6:    frame_byte = (nxt.phase == PH_CMD_IDLE) ? IDLE_CRC : FILL_BYTE;
			default: frame_byte = FILL_BYTE;
		endcase
	end

	always_comb begin
		res.data_valid = data_valid_c;
		res.data_byte  = data_byte_c;
		res.data_last  = data_last_c;
		res.status     = status_c;
		unique case (nxt.phase)
			PH_IDLE: begin
				res.tx_valid    = 1'b0;
				res.tx_byte     = 8'h00;
				res.card_select = 1'b0;
			end
			PH_WAKE: begin
				res.tx_valid    = 1'b1;
				res.tx_byte     = FILL_BYTE;
				res.card_select = 1'b0;
			end
			PH_CMD_IDLE, PH_CMD_OP, PH_CMD_READ: begin
				res.tx_valid    = 1'b1;
				res.tx_byte     = frame_byte;
				res.card_select = 1'b1;
			end
			default: begin
				res.tx_valid    = 1'b1;
				res.tx_byte     = FILL_BYTE;
				res.card_select = 1'b1;
			end
		endcase
	end

endmodule

>>> rtl/core/mmc_spi_host_sequencer_unit.sv
// top level of the mmc spi host sequencer
// Each transaction on the input channel is one step of the card protocol: a start
// of init, a start of a sector read, or the byte received in the last spi exchange.
// Every input transaction yields exactly one output transaction naming the next
// exchange, any sector data byte and the completion status. One transaction is taken
// per clock while the output is not stalled; an accepted input is held in the input
// register, then its result in the result register. The rate is set by the sequencer
// state update, which closes its loop through the step logic once per cycle. The user
// must write command indices through the configuration port only while no transaction
// is in flight; the block does not enforce this. Indices are sampled at the start of each command frame.
`timescale 1ns / 1ps
`include "mmc_spi_host_sequencer_unit_defines.svh"
module mmc_spi_host_sequencer_unit
	import mmc_pkg::*;
#(
	parameter int SECTOR_BYTES = 512,
	parameter int WAKE_BYTES   = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CMD_IDX_W-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data
);

	cfg_t       cfg;
	seq_state_t state_q;
	seq_state_t state_nxt;
	in_item_t   item_s1;
	logic       item_vld_s1;
	out_item_t  res_nxt;
	out_item_t  res_s2;
	logic       res_vld_s2;
	logic       adv;
	logic       in_take;

	mmc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mmc_step #(
		.SECTOR_BYTES (SECTOR_BYTES),
		.WAKE_BYTES   (WAKE_BYTES)
	) u_step (
		.cur  (state_q),
		.item (item_s1),
		.cfg  (cfg),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	assign adv      = item_vld_s1 && (!res_vld_s2 || !out_stall);
	assign in_stall = item_vld_s1 && !adv;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else if (in_take) begin
			item_vld_s1 <= 1'b1;
		end else if (adv) begin
			item_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase         <= PH_IDLE;
			state_q.operation     <= OP_INIT;
			state_q.frame_index   <= '0;
			state_q.byte_count    <= '0;
			state_q.address_latch <= '0;
			state_q.command_index <= '0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_s2 <= 1'b0;
		end else if (adv) begin
			res_vld_s2 <= 1'b1;
		end else if (!out_stall) begin
			res_vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid = res_vld_s2;
	assign out_data  = res_s2;

	`MMC_ASSERT(a_last_has_data, res_vld_s2 |-> (!res_s2.data_last || res_s2.data_valid), "data_last without data_valid")
	`MMC_ASSERT(a_end_stops_tx, (res_vld_s2 && res_s2.status != ST_BUSY) |-> !res_s2.tx_valid, "completion status with a pending exchange")
	`MMC_ASSERT(a_tx_matches_phase, $past(adv) |-> (res_s2.tx_valid == (state_q.phase != PH_IDLE)), "pending exchange disagrees with sequencer phase")
	`MMC_ASSERT_ALWAYS(a_stall_needs_item, in_stall |-> item_vld_s1, "input stalled with empty input register")

endmodule

>>> sim/exchange_check_pkg.sv
// expected-exchange tracker for the mmc spi host sequencer testbench
`timescale 1ns / 1ps
package exchange_check_pkg;
	import mmc_pkg::*;

	class exchange_tracker;
		int sector_bytes;
		int wake_bytes;
		cfg_t regs;
		seq_state_t st;
		out_item_t awaited[$];
		int errors;

		function new(int sector_bytes, int wake_bytes);
			this.sector_bytes = sector_bytes;
			this.wake_bytes = wake_bytes;
			regs.idle_cmd_index = IDLE_CMD_RST;
			regs.opmode_cmd_index = OPMODE_CMD_RST;
			regs.read_cmd_index = READ_CMD_RST;
			st = '0;
			st.phase = PH_IDLE;
			errors = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CMD_IDX_W-1:0] value);
			case (idx)
			REG_IDLE_CMD: regs.idle_cmd_index = value;
			REG_OPMODE_CMD: regs.opmode_cmd_index = value;
			REG_READ_CMD: regs.read_cmd_index = value;
			default: ;
			endcase
		endfunction

		// command index and address are held for the whole frame
		function void open_frame(phase_t ph, logic [CMD_IDX_W-1:0] idx, logic [31:0] addr);
			st.phase = ph;
			st.frame_index = '0;
			st.command_index = idx;
			st.address_latch = addr;
		endfunction

		function logic [7:0] frame_byte();
			case (st.frame_index)
			4'd1: return CMD_MARK | {2'b00, st.command_index};
			4'd2: return st.address_latch[31:24];
			4'd3: return st.address_latch[23:16];
			4'd4: return st.address_latch[15:8];
			4'd5: return st.address_latch[7:0];
			4'd6: return (st.phase == PH_CMD_IDLE) ? IDLE_CRC : FILL_BYTE;
			default: return FILL_BYTE;
			endcase
		endfunction

		function void note_input(in_item_t it);
			out_item_t r;
			r = '0;
			case (it.command)
			CMD_INIT: begin
				st.operation = OP_INIT;
				st.phase = PH_WAKE;
				st.byte_count = '0;
				st.frame_index = '0;
			end
			CMD_READ: begin
				st.operation = OP_READ;
				st.byte_count = '0;
				open_frame(PH_CMD_READ, regs.read_cmd_index, it.sector_address);
			end
			CMD_BYTE: begin
				case (st.phase)
				PH_WAKE: begin
					st.byte_count = st.byte_count + 1'b1;
					if (st.byte_count >= wake_bytes)
						open_frame(PH_CMD_IDLE, regs.idle_cmd_index, '0);
				end
				PH_CMD_IDLE, PH_CMD_OP, PH_CMD_READ: begin
					if (st.frame_index < FRAME_LAST) begin
						st.frame_index = st.frame_index + 1'b1;
					end else if (st.phase == PH_CMD_IDLE) begin
						if (it.rx_byte == RESP_IDLE) begin
							open_frame(PH_CMD_OP, regs.opmode_cmd_index, '0);
						end else begin
							st.phase = PH_IDLE;
							r.status = ST_REJECT;
						end
					end else if (st.phase == PH_CMD_OP) begin
						if (it.rx_byte == RESP_READY) begin
							st.phase = PH_IDLE;
							r.status = ST_DONE;
						end else begin
							st.frame_index = '0;
						end
					end else begin
						st.phase = PH_TOKEN;
					end
				end
				PH_TOKEN: begin
					if (it.rx_byte == DATA_TOKEN) begin
						st.phase = PH_DATA;
						st.byte_count = '0;
					end
				end
				PH_DATA: begin
					r.data_valid = 1'b1;
					r.data_byte = it.rx_byte;
					if (int'(st.byte_count) + 1 >= sector_bytes) begin
						r.data_last = 1'b1;
						st.phase = PH_CRC;
						st.byte_count = '0;
					end else begin
						st.byte_count = st.byte_count + 1'b1;
					end
				end
				PH_CRC: begin
					st.byte_count = st.byte_count + 1'b1;
					if (st.byte_count >= 2) begin
						st.phase = PH_IDLE;
						st.byte_count = '0;
						r.status = ST_DONE;
					end
				end
				default: st.phase = PH_IDLE;
				endcase
			end
			default: ;
			endcase

			if (st.phase != PH_IDLE) begin
				r.tx_valid = 1'b1;
				r.card_select = (st.phase != PH_WAKE);
				case (st.phase)
				PH_CMD_IDLE, PH_CMD_OP, PH_CMD_READ: r.tx_byte = frame_byte();
				default: r.tx_byte = FILL_BYTE;
				endcase
			end
			awaited.push_back(r);
		endfunction

		function void compare(string field, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (awaited.size() == 0) begin
				$error("unexpected output transaction %h", got);
				errors++;
				return;
			end
			want = awaited.pop_front();
			compare("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
			compare("tx_byte", want.tx_byte, got.tx_byte);
			compare("card_select", 8'(want.card_select), 8'(got.card_select));
			compare("data_valid", 8'(want.data_valid), 8'(got.data_valid));
			compare("data_byte", want.data_byte, got.data_byte);
			compare("data_last", 8'(want.data_last), 8'(got.data_last));
			compare("status", 8'(want.status), 8'(got.status));
		endfunction
	endclass

endpackage

>>> sim/tb_top.sv
// top-level testbench of the mmc spi host sequencer
`timescale 1ns / 1ps
module tb_top;
	import mmc_pkg::*;
	import exchange_check_pkg::*;

	localparam int SECTOR_BYTES = 512;
	localparam int WAKE_BYTES = 10;
	localparam int RANDOM_ITEMS = 920;
	localparam logic [1:0] CMD_NONE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CMD_IDX_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;

	bit calm = 1'b0;
	int items_sent = 0;
	exchange_tracker tracker;

	always #4 clk = ~clk;

	mmc_spi_host_sequencer_unit #(
		.SECTOR_BYTES(SECTOR_BYTES),
		.WAKE_BYTES(WAKE_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 23);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_result(out_data);
	end

	task automatic send(logic [1:0] cmd, logic [31:0] addr, logic [7:0] rx);
		in_item_t it;
		it.command = cmd;
		it.sector_address = addr;
		it.rx_byte = rx;
		while (!calm && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		tracker.note_input(it);
		items_sent++;
	endtask

	task automatic send_rx(logic [7:0] rx);
		send(CMD_BYTE, $urandom, rx);
	endtask

	// every transaction yields one result, so an empty queue means the block is idle
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.awaited.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_regs(logic [CMD_IDX_W-1:0] idle_idx, logic [CMD_IDX_W-1:0] op_idx,
			logic [CMD_IDX_W-1:0] rd_idx);
		logic [CFG_IDX_W-1:0] sel[3] = '{REG_IDLE_CMD, REG_OPMODE_CMD, REG_READ_CMD};
		logic [CMD_IDX_W-1:0] vals[3];
		vals = '{idle_idx, op_idx, rd_idx};
		for (int i = 0; i < 3; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= sel[i];
			cfg_data <= vals[i];
			@(posedge clk);
			tracker.write_reg(sel[i], vals[i]);
		end
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_init();
		logic [7:0] rsp;
		int polls;
		send(CMD_INIT, $urandom, 8'($urandom));
		repeat (WAKE_BYTES) send_rx(8'($urandom));
		repeat (FRAME_LAST) send_rx(8'($urandom));
		if ($urandom_range(99) < 20) begin
			rsp = 8'($urandom);
			if (rsp == RESP_IDLE)
				rsp = RESP_READY;
			send_rx(rsp);
			return;
		end
		send_rx(RESP_IDLE);
		polls = $urandom_range(1, 3);
		for (int p = 0; p < polls; p++) begin
			repeat (FRAME_LAST) send_rx(8'($urandom));
			if (p == polls - 1)
				send_rx(RESP_READY);
			else
				send_rx(8'($urandom_range(1, 255)));
		end
	endtask

	task automatic run_read(int data_bytes);
		logic [31:0] addr;
		logic [7:0] b;
		case ($urandom_range(3))
		0: addr = '0;
		1: addr = '1;
		default: addr = $urandom;
		endcase
		send(CMD_READ, addr, 8'($urandom));
		repeat (FRAME_LAST + 1) send_rx(8'($urandom));
		repeat ($urandom_range(0, 6)) begin
			b = 8'($urandom);
			if (b == DATA_TOKEN)
				b = FILL_BYTE;
			send_rx(b);
		end
		send_rx(DATA_TOKEN);
		repeat (data_bytes) send_rx(8'($urandom));
		if (data_bytes >= SECTOR_BYTES)
			repeat (2) send_rx(8'($urandom));
	endtask

	task automatic run_random(int count);
		int stop;
		int pick;
		stop = items_sent + count;
		while (items_sent < stop) begin
			pick = $urandom_range(99);
			if (pick < 40)
				run_init();
			else if (pick < 55 && stop - items_sent > SECTOR_BYTES + 32)
				run_read(SECTOR_BYTES);
			else if (pick < 70)
				run_read($urandom_range(0, 64));
			else
				repeat ($urandom_range(1, 12))
					send(2'($urandom_range(3)), $urandom, 8'($urandom));
		end
	endtask

	initial begin
		tracker = new(SECTOR_BYTES, WAKE_BYTES);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on reset register values
		send(CMD_BYTE, '1, FILL_BYTE);
		send(CMD_NONE, '1, 8'h00);
		send(CMD_INIT, '0, 8'h00);
		repeat (3) send_rx(8'h00);
		send(CMD_NONE, '0, 8'hFF);
		send(CMD_READ, '1, 8'h00);
		repeat (4) send_rx(8'hFF);
		send(CMD_NONE, '0, 8'h00);
		send(CMD_READ, '0, 8'hFF);
		repeat (2) send_rx(8'h00);
		// register write part way through a frame
		drain();
		write_regs('1, '1, '1);
		repeat (7) send_rx(8'hFF);
		// one whole sector with its crc bytes
		run_read(SECTOR_BYTES);

		run_random(RANDOM_ITEMS / 4);
		drain();
		write_regs('0, '0, '0);
		run_random(RANDOM_ITEMS / 4);
		drain();
		write_regs(CMD_IDX_W'($urandom), CMD_IDX_W'($urandom), CMD_IDX_W'($urandom));
		calm = 1'b1;
		run_random(RANDOM_ITEMS / 4);
		calm = 1'b0;
		drain();
		write_regs(IDLE_CMD_RST, OPMODE_CMD_RST, READ_CMD_RST);
		run_random(RANDOM_ITEMS / 4);
		drain();

		if (tracker.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule
